FILE: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property a must be followed in the same cycle by b.
`define ASSERT_IMPLIES(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("assertion failed: implication");

// Property a must never hold.
`define ASSERT_NEVER(label, a) \
   label: assert property (@(posedge clock) disable iff (reset) !(a)) \
      else $error("assertion failed: forbidden condition");

`endif

FILE: hdl/twrm_pkg.sv
// Types and constants for the three-wire register master.
package twrm_pkg;

   localparam int ADDRESS_BITS = 7;
   localparam int DATA_BITS    = 8;
   localparam int FRAME_BITS   = 1 + ADDRESS_BITS + DATA_BITS;
   localparam int BIT_NUM_W    = $clog2(FRAME_BITS + 1);
   localparam int BIT_IDX_W    = $clog2(FRAME_BITS);

   localparam logic [7:0] SETUP_TICKS_RESET = 8'd5;
   localparam logic [7:0] HIGH_TICKS_RESET  = 8'd5;
   localparam logic [7:0] LOW_TICKS_RESET   = 8'd10;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_SETUP_TICKS = 2'd0,
      CSR_HIGH_TICKS  = 2'd1,
      CSR_LOW_TICKS   = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_SETUP = 2'd0,
      PH_HIGH  = 2'd1,
      PH_LOW   = 2'd2
   } phase_type;

   typedef struct packed {
      opcode_type                opcode;
      logic [ADDRESS_BITS-1:0]   address;
      logic [DATA_BITS-1:0]      write_data;
      logic                      sdata_in;
   } req_type;

   typedef struct packed {
      logic                      enable_n;
      logic                      serial_clock;
      logic                      data_out;
      logic                      data_drive;
      logic                      busy_res;
      logic                      done_res;
      logic [DATA_BITS-1:0]      read_data;
      logic                      rejected;
   } rsp_type;

   typedef struct packed {
      logic [7:0] setup_ticks;
      logic [7:0] high_ticks;
      logic [7:0] low_ticks;
   } cfg_type;

   typedef struct packed {
      logic active;
   } status_type;

endpackage

FILE: hdl/twrm_core.sv
// Frame sequencer: state registers and per-transfer next-state and result logic.
module twrm_core (
   input  logic              clock,
   input  logic              reset,
   input  twrm_pkg::cfg_type cfg,
   input  logic              take,
   input  twrm_pkg::req_type req,
   output twrm_pkg::rsp_type result,
   output twrm_pkg::status_type status
);

   logic                                 active_ff, active_in;
   logic                                 read_mode_ff, read_mode_in;
   twrm_pkg::phase_type                  phase_ff, phase_in;
   logic [7:0]                           count_ff, count_in;
   logic [twrm_pkg::BIT_NUM_W-1:0]       bitnum_ff, bitnum_in;
   logic [twrm_pkg::FRAME_BITS-1:0]      out_shift_ff, out_shift_in;
   logic [twrm_pkg::DATA_BITS-1:0]       in_shift_ff, in_shift_in;
   logic [twrm_pkg::DATA_BITS-1:0]       latch_ff, latch_in;

   logic [7:0]                           phase_len;
   logic [7:0]                           count_inc;
   logic [twrm_pkg::BIT_NUM_W-1:0]       bitnum_inc;
   logic                                 cur_read_data;
   logic                                 nxt_read_data;
   logic [twrm_pkg::BIT_NUM_W-1:0]       bit_pos;
   logic                                 done;
   logic                                 rej;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         read_mode_ff <= 1'b0;
         phase_ff     <= twrm_pkg::PH_SETUP;
         count_ff     <= '0;
         bitnum_ff    <= '0;
         out_shift_ff <= '0;
         in_shift_ff  <= '0;
         latch_ff     <= '0;
      end else if (take) begin
         active_ff    <= active_in;
         read_mode_ff <= read_mode_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         bitnum_ff    <= bitnum_in;
         out_shift_ff <= out_shift_in;
         in_shift_ff  <= in_shift_in;
         latch_ff     <= latch_in;
      end
   end

   always_comb begin
      case (phase_ff)
         twrm_pkg::PH_SETUP: phase_len = cfg.setup_ticks;
         twrm_pkg::PH_HIGH:  phase_len = cfg.high_ticks;
         default:            phase_len = cfg.low_ticks;
      endcase
      if (phase_len == 8'd0) begin
         phase_len = 8'd1;
      end
   end

   assign count_inc     = count_ff + 8'd1;
   assign bitnum_inc    = bitnum_ff + twrm_pkg::BIT_NUM_W'(1);
   assign cur_read_data = read_mode_ff &&
                          (bitnum_ff >= twrm_pkg::BIT_NUM_W'(1 + twrm_pkg::ADDRESS_BITS));

   always_comb begin
      active_in    = active_ff;
      read_mode_in = read_mode_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      bitnum_in    = bitnum_ff;
      out_shift_in = out_shift_ff;
      in_shift_in  = in_shift_ff;
      latch_in     = latch_ff;
      done         = 1'b0;
      rej          = 1'b0;
      case (req.opcode)
         twrm_pkg::OP_WRITE, twrm_pkg::OP_READ: begin
            if (active_ff) begin
               rej = 1'b1;
            end else begin
               active_in    = 1'b1;
               read_mode_in = (req.opcode == twrm_pkg::OP_READ);
               phase_in     = twrm_pkg::PH_SETUP;
               count_in     = '0;
               bitnum_in    = '0;
               in_shift_in  = '0;
               out_shift_in = {read_mode_in, req.address,
                               read_mode_in ? {twrm_pkg::DATA_BITS{1'b0}} : req.write_data};
            end
         end
         twrm_pkg::OP_TICK: begin
            if (active_ff) begin
               if (count_inc < phase_len) begin
                  count_in = count_inc;
               end else begin
                  count_in = '0;
                  case (phase_ff)
                     twrm_pkg::PH_SETUP: begin
                        if (cur_read_data) begin
                           in_shift_in = {in_shift_ff[twrm_pkg::DATA_BITS-2:0], req.sdata_in};
                        end
                        phase_in = twrm_pkg::PH_HIGH;
                     end
                     twrm_pkg::PH_HIGH: begin
                        phase_in = twrm_pkg::PH_LOW;
                     end
                     default: begin
                        phase_in  = twrm_pkg::PH_SETUP;
                        bitnum_in = bitnum_inc;
                        if (bitnum_inc >= twrm_pkg::BIT_NUM_W'(twrm_pkg::FRAME_BITS)) begin
                           if (read_mode_ff) begin
                              latch_in = in_shift_ff;
                           end
                           active_in = 1'b0;
                           bitnum_in = '0;
                           done      = 1'b1;
                        end
                     end
                  endcase
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign nxt_read_data = read_mode_in &&
                          (bitnum_in >= twrm_pkg::BIT_NUM_W'(1 + twrm_pkg::ADDRESS_BITS));
   assign bit_pos       = twrm_pkg::BIT_NUM_W'(twrm_pkg::FRAME_BITS - 1) - bitnum_in;

   always_comb begin
      result.enable_n     = !active_in;
      result.serial_clock = active_in && (phase_in == twrm_pkg::PH_HIGH);
      result.data_drive   = active_in && !nxt_read_data;
      result.data_out     = result.data_drive &&
                            out_shift_in[bit_pos[twrm_pkg::BIT_IDX_W-1:0]];
      result.busy_res     = active_in;
      result.done_res     = done;
      result.read_data    = latch_in;
      result.rejected     = rej;
   end

   assign status.active = active_ff;

endmodule

FILE: hdl/twrm_rsp_fifo.sv
// Two-entry result buffer between the sequencer and the result channel.
module twrm_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  twrm_pkg::rsp_type push_data,
   output logic              not_full,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output twrm_pkg::rsp_type rsp_data
);

   twrm_pkg::rsp_type mem_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff;
   logic              pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign not_full  = (count_ff != 2'd2);
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

FILE: hdl/three_wire_register_master_unit.sv
// Top level of the three-wire serial register port master.
// Each request transfer (tick, start write, start read, nop) yields exactly one response
// transfer showing the port pins and status after that request. A request is taken every
// cycle while req_ready is high; the sequencer state updates in the accepting cycle and the
// response lands in a two-entry buffer; req_ready drops only when two responses wait.
// Frame timing is set entirely by tick requests and the three phase-length registers.
`include "assert_macros.svh"

module three_wire_register_master_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  twrm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output twrm_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_write_data
);

   twrm_pkg::cfg_type    cfg_ff;
   twrm_pkg::rsp_type    result;
   twrm_pkg::status_type status;
   logic                 take;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setup_ticks <= twrm_pkg::SETUP_TICKS_RESET;
         cfg_ff.high_ticks  <= twrm_pkg::HIGH_TICKS_RESET;
         cfg_ff.low_ticks   <= twrm_pkg::LOW_TICKS_RESET;
      end else if (csr_write_enable) begin
         case (twrm_pkg::csr_index_type'(csr_index))
            twrm_pkg::CSR_SETUP_TICKS: cfg_ff.setup_ticks <= csr_write_data;
            twrm_pkg::CSR_HIGH_TICKS:  cfg_ff.high_ticks  <= csr_write_data;
            twrm_pkg::CSR_LOW_TICKS:   cfg_ff.low_ticks   <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign take = req_valid && req_ready;

   twrm_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .take   (take),
      .req    (req_data),
      .result (result),
      .status (status)
   );

   twrm_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_data (result),
      .not_full  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `ASSERT_IMPLIES(a_done_ends_frame, take && result.done_res, status.active && !result.busy_res)
   `ASSERT_IMPLIES(a_reject_when_busy, take && result.rejected, status.active && result.busy_res)
   `ASSERT_IMPLIES(a_enable_tracks_busy, take, result.enable_n == !result.busy_res)
   `ASSERT_NEVER(a_clock_while_idle, take && result.serial_clock && !result.busy_res)

endmodule
